// File: rtl/tfn_pkg.sv
`timescale 1ns / 1ps

package tfn_pkg;

   // mantissa width of the normalised cross product
   localparam int MANT_BITS = 30;
   // root width: the sum of three squared mantissas stays below 2^(2*ROOT_BITS)
   localparam int ROOT_BITS = MANT_BITS + 1;
   // chunk width of the leading-one search
   localparam int CHUNK_BITS = 8;
   localparam int CHUNK_LEN_BITS = $clog2(CHUNK_BITS + 1);

   // sign of each cross component and the zero-vector flag
   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } tfn_sign_type;

   // what travels beside the square root
   typedef struct packed {
      logic [2:0][MANT_BITS-1:0] mant;
      tfn_sign_type              sign;
   } tfn_side_type;

endpackage

// File: rtl/tfn_isqrt.sv
`timescale 1ns / 1ps

module tfn_isqrt #(
   parameter int RB = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [2*RB-1:0]      in_rad,
   input  tfn_pkg::tfn_side_type in_side,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [RB-1:0]        out_root,
   output tfn_pkg::tfn_side_type out_side
);
   import tfn_pkg::*;

   localparam int SW = 2 * RB;

   logic [SW-1:0] x_ff [RB];
   logic [SW-1:0] r_ff [RB];
   tfn_side_type  side_ff [RB];
   logic [RB-1:0] vld_ff;
   logic [RB-1:0] rdy;

   // ready ripples back through empty stages
   always_comb begin
      rdy[RB-1] = !vld_ff[RB-1] || out_ready;
      for (int j = RB - 2; j >= 0; j--) begin
         rdy[j] = !vld_ff[j] || rdy[j+1];
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         for (int j = 1; j < RB; j++) begin
            if (rdy[j]) vld_ff[j] <= vld_ff[j-1];
         end
      end
   end

   // one root bit per stage, digit-by-digit method
   for (genvar j = 0; j < RB; j++) begin : g_stage
      localparam logic [SW-1:0] BIT = SW'(1) << (2 * (RB - 1 - j));
      logic [SW-1:0] x_prev, r_prev, x_in, r_in, trial;
      tfn_side_type  side_prev;

      if (j == 0) begin : g_first
         assign x_prev    = in_rad;
         assign r_prev    = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign x_prev    = x_ff[j-1];
         assign r_prev    = r_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      assign trial = r_prev + BIT;

      always_comb begin
         if (x_prev >= trial) begin
            x_in = x_prev - trial;
            r_in = (r_prev >> 1) + BIT;
         end else begin
            x_in = x_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[j]) begin
            x_ff[j]    <= x_in;
            r_ff[j]    <= r_in;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[RB-1];
   assign out_root  = r_ff[RB-1][RB-1:0];
   assign out_side  = side_ff[RB-1];

endmodule

// File: rtl/tfn_div.sv
`timescale 1ns / 1ps

module tfn_div #(
   parameter int RB = 31,
   parameter int FB = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [2:0][tfn_pkg::MANT_BITS-1:0] in_mant,
   input  logic [RB-1:0]                     in_root,
   input  tfn_pkg::tfn_sign_type             in_sign,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [2:0][FB:0]                  out_quo,
   output tfn_pkg::tfn_sign_type             out_sign
);
   import tfn_pkg::*;

   localparam int QB = FB + 1;
   localparam int DW = RB + FB;
   localparam int NS = QB + 1;

   logic [2:0][DW-1:0] rem_ff [NS];
   logic [2:0][QB-1:0] quo_ff [NS];
   logic [RB-1:0]      dv_ff  [NS];
   tfn_sign_type       sg_ff  [NS];
   logic [NS-1:0]      vld_ff;
   logic [NS-1:0]      rdy;

   always_comb begin
      rdy[NS-1] = !vld_ff[NS-1] || out_ready;
      for (int j = NS - 2; j >= 0; j--) begin
         rdy[j] = !vld_ff[j] || rdy[j+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         for (int j = 1; j < NS; j++) begin
            if (rdy[j]) vld_ff[j] <= vld_ff[j-1];
         end
      end
   end

   // form rounded numerators: mant * 2^FB + root / 2
   logic [2:0][DW-1:0] num_in;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num_in[k] = DW'({in_mant[k], {FB{1'b0}}}) + DW'(in_root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         rem_ff[0] <= num_in;
         quo_ff[0] <= '0;
         dv_ff[0]  <= in_root;
         sg_ff[0]  <= in_sign;
      end
   end

   // one quotient bit per stage, restoring division on three lanes
   for (genvar j = 1; j < NS; j++) begin : g_stage
      localparam int K = QB - j;
      logic [DW-1:0]      dsh;
      logic [2:0][DW-1:0] rem_in;
      logic [2:0][QB-1:0] quo_in;

      assign dsh = DW'(dv_ff[j-1]) << K;

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            if (rem_ff[j-1][k] >= dsh) begin
               rem_in[k] = rem_ff[j-1][k] - dsh;
               quo_in[k] = {quo_ff[j-1][k][QB-2:0], 1'b1};
            end else begin
               rem_in[k] = rem_ff[j-1][k];
               quo_in[k] = {quo_ff[j-1][k][QB-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[j]) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
            dv_ff[j]  <= dv_ff[j-1];
            sg_ff[j]  <= sg_ff[j-1];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NS-1];
   assign out_quo   = quo_ff[NS-1];
   assign out_sign  = sg_ff[NS-1];

endmodule

// File: rtl/triangle_face_normal.sv
`timescale 1ns / 1ps
// Pipeline of ten front stages, one stage per root bit of the square root, NORMAL_FRAC_BITS + 2
// stages of the divider and one output register. Throughput: one triangle per cycle; every stage
// holds its beat under backpressure and empty stages fill up. Reset clears all valid bits, also the
// output valid; data registers, the output data register among them, are not reset.
module triangle_face_normal #(
   parameter int COORD_BITS       = 32,
   parameter int NORMAL_FRAC_BITS = 14,
   localparam int REQ_TDW = ((9 * COORD_BITS + 7) / 8) * 8,
   localparam int OB      = NORMAL_FRAC_BITS + 2,
   localparam int RSP_TDW = ((3 * OB + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
   input  logic [REQ_TDW-1:0] req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // normal_x, normal_y, normal_z from bit 0 up
   output logic [RSP_TDW-1:0] rsp_tdata,
   // degenerate
   output logic [0:0]         rsp_tuser
);
   import tfn_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int F   = NORMAL_FRAC_BITS;
   localparam int UW  = C + 1;
   localparam int HL  = UW / 2;
   localparam int HH  = UW - HL;
   localparam int PW  = 2 * UW;
   localparam int XW  = PW + 1;
   localparam int NCH = (XW + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int LW  = $clog2(XW + 1);
   localparam int SW  = 2 * ROOT_BITS;
   localparam int QB  = F + 1;
   localparam int NF  = 10;
   localparam int PA [6] = '{1, 2, 2, 0, 0, 1};
   localparam int PB [6] = '{2, 1, 0, 2, 1, 0};

   logic [NF-1:0] f_vld_ff;
   logic [NF-1:0] f_rdy;
   logic          sq_in_ready;

   // ready ripples back through empty front stages
   always_comb begin
      f_rdy[NF-1] = !f_vld_ff[NF-1] || sq_in_ready;
      for (int i = NF - 2; i >= 0; i--) begin
         f_rdy[i] = !f_vld_ff[i] || f_rdy[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= '0;
      end else begin
         if (f_rdy[0]) f_vld_ff[0] <= req_tvalid;
         for (int i = 1; i < NF; i++) begin
            if (f_rdy[i]) f_vld_ff[i] <= f_vld_ff[i-1];
         end
      end
   end

   assign req_tready = f_rdy[0];

   // stage 0: edge vectors
   logic signed [UW-1:0] u_in [3], v_in [3], u_ff [3], v_ff [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_in[k] = UW'($signed(req_tdata[(3 + k) * C +: C]))
                 - UW'($signed(req_tdata[k * C +: C]));
         v_in[k] = UW'($signed(req_tdata[(6 + k) * C +: C]))
                 - UW'($signed(req_tdata[k * C +: C]));
      end
   end
   always_ff @(posedge clock) begin
      if (f_rdy[0]) begin
         u_ff <= u_in;
         v_ff <= v_in;
      end
   end

   // stage 1: partial products of the six cross terms
   logic signed [2*HH-1:0] hh_ff [6];
   logic signed [UW:0]     hl_ff [6], lh_ff [6];
   logic        [2*HL-1:0] ll_ff [6];
   for (genvar p = 0; p < 6; p++) begin : g_part
      logic signed [HH-1:0] ah, bh;
      logic signed [HL:0]   al, bl;
      logic signed [2*HH-1:0] hh_in;
      logic signed [UW:0]     hl_in, lh_in;
      logic        [2*HL-1:0] ll_in;
      assign ah    = u_ff[PA[p]][UW-1:HL];
      assign bh    = v_ff[PB[p]][UW-1:HL];
      assign al    = $signed({1'b0, u_ff[PA[p]][HL-1:0]});
      assign bl    = $signed({1'b0, v_ff[PB[p]][HL-1:0]});
      assign hh_in = ah * bh;
      assign hl_in = ah * bl;
      assign lh_in = al * bh;
      assign ll_in = u_ff[PA[p]][HL-1:0] * v_ff[PB[p]][HL-1:0];
      always_ff @(posedge clock) begin
         if (f_rdy[1]) begin
            hh_ff[p] <= hh_in;
            hl_ff[p] <= hl_in;
            lh_ff[p] <= lh_in;
            ll_ff[p] <= ll_in;
         end
      end
   end

   // stage 2: add up partial products
   logic signed [PW-1:0] prod_in [6], prod_ff [6];
   always_comb begin
      for (int p = 0; p < 6; p++) begin
         prod_in[p] = $signed((PW'(hh_ff[p]) << (2 * HL))
                    + ((PW'(hl_ff[p]) + PW'(lh_ff[p])) << HL) + PW'(ll_ff[p]));
      end
   end
   always_ff @(posedge clock) begin
      if (f_rdy[2]) prod_ff <= prod_in;
   end

   // stage 3: cross product components
   logic signed [XW-1:0] cross_in [3], cross_ff [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cross_in[k] = XW'(prod_ff[2*k]) - XW'(prod_ff[2*k+1]);
      end
   end
   always_ff @(posedge clock) begin
      if (f_rdy[3]) cross_ff <= cross_in;
   end

   // stage 4: split into sign and magnitude
   logic [XW-1:0] mag_in [3], mag4_ff [3], mag5_ff [3], mag6_ff [3];
   tfn_sign_type  sg_in, sg4_ff, sg5_ff, sg6_ff, sg7_ff, sg8_ff, sg9_ff;
   always_comb begin
      sg_in.degen = 1'b0;
      for (int k = 0; k < 3; k++) begin
         sg_in.neg[k] = cross_ff[k][XW-1];
         mag_in[k]    = cross_ff[k][XW-1] ? XW'(-cross_ff[k]) : XW'(cross_ff[k]);
      end
   end
   always_ff @(posedge clock) begin
      if (f_rdy[4]) begin
         mag4_ff <= mag_in;
         sg4_ff  <= sg_in;
      end
   end

   // stage 5: leading-one position inside each chunk
   logic [NCH*CHUNK_BITS-1:0] all_mag;
   logic [CHUNK_LEN_BITS-1:0] clen_in [NCH], clen_ff [NCH];
   assign all_mag = (NCH * CHUNK_BITS)'(mag4_ff[0] | mag4_ff[1] | mag4_ff[2]);
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         clen_in[c] = '0;
         for (int b = 0; b < CHUNK_BITS; b++) begin
            if (all_mag[c * CHUNK_BITS + b]) clen_in[c] = CHUNK_LEN_BITS'(b + 1);
         end
      end
   end
   always_ff @(posedge clock) begin
      if (f_rdy[5]) begin
         clen_ff <= clen_in;
         mag5_ff <= mag4_ff;
         sg5_ff  <= sg4_ff;
      end
   end

   // stage 6: bit length of the largest magnitude
   logic [LW-1:0] len_in, len_ff;
   always_comb begin
      len_in = '0;
      for (int c = 0; c < NCH; c++) begin
         if (clen_ff[c] != '0) len_in = LW'(c * CHUNK_BITS) + LW'(clen_ff[c]);
      end
   end
   always_ff @(posedge clock) begin
      if (f_rdy[6]) begin
         len_ff  <= len_in;
         mag6_ff <= mag5_ff;
         sg6_ff  <= sg5_ff;
      end
   end

   // stage 7: shift so the longest magnitude fills the mantissa
   logic [MANT_BITS-1:0] mant_in [3], mant7_ff [3], mant8_ff [3], mant9_ff [3];
   tfn_sign_type         sg7_in;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mant_in[k] = MANT_BITS'({mag6_ff[k], {MANT_BITS{1'b0}}} >> len_ff);
      end
      sg7_in       = sg6_ff;
      sg7_in.degen = (len_ff == '0);
   end
   always_ff @(posedge clock) begin
      if (f_rdy[7]) begin
         mant7_ff <= mant_in;
         sg7_ff   <= sg7_in;
      end
   end

   // stage 8: squares
   logic [2*MANT_BITS-1:0] sq_in [3], sq_ff [3];
   always_comb begin
      for (int k = 0; k < 3; k++) sq_in[k] = mant7_ff[k] * mant7_ff[k];
   end
   always_ff @(posedge clock) begin
      if (f_rdy[8]) begin
         sq_ff    <= sq_in;
         mant8_ff <= mant7_ff;
         sg8_ff   <= sg7_ff;
      end
   end

   // stage 9: squared length
   logic [SW-1:0] rad_in, rad_ff;
   assign rad_in = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
   always_ff @(posedge clock) begin
      if (f_rdy[9]) begin
         rad_ff   <= rad_in;
         mant9_ff <= mant8_ff;
         sg9_ff   <= sg8_ff;
      end
   end

   // square root
   tfn_side_type         side_in, side_out;
   logic                 sq_out_valid, dv_in_ready;
   logic [ROOT_BITS-1:0] root;
   always_comb begin
      for (int k = 0; k < 3; k++) side_in.mant[k] = mant9_ff[k];
      side_in.sign = sg9_ff;
   end

   tfn_isqrt #(
      .RB (ROOT_BITS)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_vld_ff[NF-1]),
      .in_ready  (sq_in_ready),
      .in_rad    (rad_ff),
      .in_side   (side_in),
      .out_valid (sq_out_valid),
      .out_ready (dv_in_ready),
      .out_root  (root),
      .out_side  (side_out)
   );

   // divide each mantissa by the length
   logic              dv_out_valid, out_rdy;
   logic [2:0][QB-1:0] quo;
   tfn_sign_type      dv_sign;

   tfn_div #(
      .RB (ROOT_BITS),
      .FB (F)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_out_valid),
      .in_ready  (dv_in_ready),
      .in_mant   (side_out.mant),
      .in_root   (root),
      .in_sign   (side_out.sign),
      .out_valid (dv_out_valid),
      .out_ready (out_rdy),
      .out_quo   (quo),
      .out_sign  (dv_sign)
   );

   // output register: apply signs, zero a degenerate normal
   logic [2:0][OB-1:0] norm_in, norm_ff;
   logic               degen_ff, rsp_vld_ff;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dv_sign.degen) norm_in[k] = '0;
         else if (dv_sign.neg[k]) norm_in[k] = OB'(-OB'(quo[k]));
         else norm_in[k] = OB'(quo[k]);
      end
   end

   assign out_rdy = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_vld_ff <= dv_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         norm_ff  <= norm_in;
         degen_ff <= dv_sign.degen;
      end
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = RSP_TDW'(norm_ff);
   assign rsp_tuser[0] = degen_ff;

   // checks
   localparam logic signed [OB-1:0] UNIT = OB'(1) << F;
   logic norm_ok;
   always_comb begin
      norm_ok = 1'b1;
      for (int k = 0; k < 3; k++) begin
         if ($signed(norm_ff[k]) > UNIT || $signed(norm_ff[k]) < -UNIT) norm_ok = 1'b0;
      end
   end

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && degen_ff |-> norm_ff == '0)
      else $error("degenerate result with non-zero normal");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> norm_ok)
      else $error("normal component beyond unit magnitude");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_vld_ff && f_vld_ff == '0)
      else $error("valid bits survive reset");

endmodule
